### sv/yellow_line_centroid_angle_defines.svh
// Assertion macros used by the file that checks this block.
`ifndef YELLOW_LINE_CENTROID_ANGLE_DEFINES_SVH
`define YELLOW_LINE_CENTROID_ANGLE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define YLCA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define YLCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### sv/ylca_pkg.sv
package ylca_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_PIXELS = 1048576;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int WIDTH_W = 11;
  localparam int THR_W   = 10;
  localparam int FOV_W   = 14;
  localparam int SUM_W   = 30;
  localparam int CNT_W   = 21;
  localparam int ANG_W   = 14;
  localparam int DIST_W  = 10;

  localparam logic [SUM_W-1:0] SUM_CAP = {SUM_W{1'b1}};
  localparam int TALLY_CAP_I = (MAX_PIXELS < (2**CNT_W - 1)) ? MAX_PIXELS : (2**CNT_W - 1);
  localparam logic [CNT_W-1:0] TALLY_CAP = CNT_W'(TALLY_CAP_I);

  // Angle arithmetic: tally*width, then fov*|2*sum - tally*width| over 2*tally*width.
  localparam int CW_W   = CNT_W + WIDTH_W;
  localparam int NUM_W  = FOV_W + CW_W;
  localparam int QBITS  = ANG_W;
  localparam int DVS_W  = CW_W + QBITS;
  localparam int DIVC_W = $clog2(QBITS);

  localparam logic [ANG_W-1:0] ANG_MAX     = {1'b0, {(ANG_W-1){1'b1}}};
  localparam logic [ANG_W-1:0] ANG_MIN     = {1'b1, {(ANG_W-1){1'b0}}};
  localparam logic [QBITS:0]   ANG_MIN_MAG = (QBITS+1)'(2**(ANG_W-1));

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_BLUE   = 3'd0,
    REG_REF_GREEN  = 3'd1,
    REG_REF_RED    = 3'd2,
    REG_THRESHOLD  = 3'd3,
    REG_WIDTH      = 3'd4,
    REG_FOV        = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   ref_blue;
    logic [PIX_W-1:0]   ref_green;
    logic [PIX_W-1:0]   ref_red;
    logic [THR_W-1:0]   match_threshold;
    logic [WIDTH_W-1:0] image_width;
    logic [FOV_W-1:0]   field_of_view;
  } cfg_t;

  typedef struct packed {
    logic acc_en;
    logic mul_cw;
    logic sub;
    logic mul_n;
    logic div_init;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_stat_t;

endpackage

### sv/ylca_regs.sv
module ylca_regs
  import ylca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ref_blue        <= PIX_W'(95);
      cfg.ref_green       <= PIX_W'(187);
      cfg.ref_red         <= PIX_W'(203);
      cfg.match_threshold <= THR_W'(30);
      cfg.image_width     <= WIDTH_W'(128);
      cfg.field_of_view   <= FOV_W'(4096);
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_REF_BLUE:  cfg.ref_blue        <= wr_data[PIX_W-1:0];
        REG_REF_GREEN: cfg.ref_green       <= wr_data[PIX_W-1:0];
        REG_REF_RED:   cfg.ref_red         <= wr_data[PIX_W-1:0];
        REG_THRESHOLD: cfg.match_threshold <= wr_data[THR_W-1:0];
        REG_WIDTH:     cfg.image_width     <= wr_data[WIDTH_W-1:0];
        REG_FOV:       cfg.field_of_view   <= wr_data[FOV_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/ylca_dp.sv
module ylca_dp
  import ylca_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic [PIX_W-1:0] pixel_blue,
  input  logic [PIX_W-1:0] pixel_green,
  input  logic [PIX_W-1:0] pixel_red,
  output logic             line_found,
  output logic [CNT_W-1:0] match_count,
  output logic [ANG_W-1:0] line_angle
);

  // accumulators
  logic [COL_W-1:0] col;
  logic [SUM_W-1:0] sum;
  logic [CNT_W-1:0] tally;

  // angle unit
  logic [CW_W-1:0]   cw;
  logic              dneg;
  logic [CW_W-1:0]   dmag;
  logic [NUM_W-1:0]  num;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [QBITS-1:0]  quo;
  logic [DIVC_W-1:0] cnt;
  logic              ovf;

  logic [PIX_W-1:0]   diff_b, diff_g, diff_r;
  logic [DIST_W-1:0]  color_dist;
  logic               hit;
  logic [SUM_W:0]     sum_ext;
  logic [SUM_W-1:0]   sum_next;
  logic [CNT_W-1:0]   tally_next;
  logic [WIDTH_W-1:0] w_eff;
  logic [COL_W:0]     col_inc;
  logic [COL_W-1:0]   col_next;
  logic signed [CW_W:0] d_full;
  logic [CW_W:0]      q_full;
  logic [QBITS:0]     qc;
  logic [QBITS:0]     qc_neg;
  logic [ANG_W-1:0]   ang;

  always_comb begin
    diff_b = (pixel_blue  > cfg.ref_blue)  ? pixel_blue  - cfg.ref_blue  : cfg.ref_blue  - pixel_blue;
    diff_g = (pixel_green > cfg.ref_green) ? pixel_green - cfg.ref_green : cfg.ref_green - pixel_green;
    diff_r = (pixel_red   > cfg.ref_red)   ? pixel_red   - cfg.ref_red   : cfg.ref_red   - pixel_red;
    color_dist = DIST_W'(diff_b) + DIST_W'(diff_g) + DIST_W'(diff_r);
    hit  = DIST_W'(color_dist) < DIST_W'(cfg.match_threshold);

    sum_ext  = {1'b0, sum} + (SUM_W+1)'(col);
    sum_next = sum_ext[SUM_W] ? SUM_CAP : sum_ext[SUM_W-1:0];
    tally_next = (tally < TALLY_CAP) ? tally + CNT_W'(1) : tally;

    if (cfg.image_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (cfg.image_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.image_width;
    end
    col_inc  = {1'b0, col} + (COL_W+1)'(1);
    col_next = (WIDTH_W'(col_inc) >= w_eff) ? '0 : col_inc[COL_W-1:0];

    d_full = $signed({2'b00, sum, 1'b0}) - $signed({1'b0, cw});
    q_full = {cw, 1'b0};

    // negative numerator: floor is minus the ceiling of the magnitude quotient
    qc     = {1'b0, quo} + (QBITS+1)'(rem != '0);
    qc_neg = (QBITS+1)'(0) - qc;
    if (tally == '0) begin
      ang = '0;
    end else if (!dneg) begin
      ang = (ovf || quo > QBITS'(ANG_MAX)) ? ANG_MAX : ANG_W'(quo);
    end else begin
      ang = (ovf || qc > ANG_MIN_MAG) ? ANG_MIN : qc_neg[ANG_W-1:0];
    end
  end

  assign stat.div_last = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      sum   <= '0;
      tally <= '0;
    end else if (cmd.load_out) begin
      col   <= '0;
      sum   <= '0;
      tally <= '0;
    end else if (cmd.acc_en) begin
      col <= col_next;
      if (hit) begin
        sum   <= sum_next;
        tally <= tally_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_cw) begin
      cw <= CW_W'(tally) * CW_W'(w_eff);
    end
    if (cmd.sub) begin
      dneg <= d_full[CW_W];
      dmag <= d_full[CW_W] ? CW_W'(-d_full) : d_full[CW_W-1:0];
    end
    if (cmd.mul_n) begin
      num <= NUM_W'(cfg.field_of_view) * NUM_W'(dmag);
    end
    if (cmd.div_init) begin
      rem <= DVS_W'(num);
      dvs <= {q_full, (QBITS-1)'(0)};
      quo <= '0;
      cnt <= DIVC_W'(QBITS-1);
      ovf <= {1'b0, num} >= {q_full, QBITS'(0)};
    end else if (cmd.div_step) begin
      if (rem >= dvs) begin
        rem <= rem - dvs;
        quo <= {quo[QBITS-2:0], 1'b1};
      end else begin
        quo <= {quo[QBITS-2:0], 1'b0};
      end
      dvs <= dvs >> 1;
      cnt <= cnt - DIVC_W'(1);
    end
    if (cmd.load_out) begin
      line_found  <= (tally != '0);
      match_count <= tally;
      line_angle  <= ang;
    end
  end

endmodule

### sv/ylca_ctrl.sv
module ylca_ctrl
  import ylca_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  input  logic     s_tlast,
  output logic     s_tready,
  output logic     m_tvalid,
  input  logic     m_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_RUN  = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_SUB  = 7'b0000100,
    ST_PROD = 7'b0001000,
    ST_INIT = 7'b0010000,
    ST_DIV  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   m_tvalid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_RUN: begin
        s_tready   = 1'b1;
        cmd.acc_en = s_tvalid;
        if (s_tvalid && s_tlast) state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_cw = 1'b1;
        state_next = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub    = 1'b1;
        state_next = ST_PROD;
      end
      ST_PROD: begin
        cmd.mul_n  = 1'b1;
        state_next = ST_INIT;
      end
      ST_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output slot is free
        if (!m_tvalid || m_tready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
    m_tvalid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RUN;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

### sv/yellow_line_centroid_angle.sv
// Pixels are taken one per cycle except while the input stalls at the end of a frame.
// After the last pixel of a frame is accepted the input stalls while the
// angle is formed by two multiplies and a 14-step restoring divider; the result is
// then loaded into the output register once the divider is done and that register is free.
// Pixels of the next frame are not taken until that result has been loaded.
// Synchronous active-high reset restores default registers and clears the column, sum and tally.
`include "yellow_line_centroid_angle_defines.svh"

module yellow_line_centroid_angle
  import ylca_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // pixel_blue, pixel_green, pixel_red
  input  logic                  s_tlast,   // end_of_frame
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // match_count, line_angle, zero pad
  output logic                  m_tuser,   // line_found
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [CNT_W-1:0] match_count;
  logic [ANG_W-1:0] line_angle;
  logic             res_zero;

  ylca_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  ylca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ylca_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .stat        (stat),
    .pixel_blue  (s_tdata[PIX_W-1:0]),
    .pixel_green (s_tdata[2*PIX_W-1:PIX_W]),
    .pixel_red   (s_tdata[3*PIX_W-1:2*PIX_W]),
    .line_found  (m_tuser),
    .match_count (match_count),
    .line_angle  (line_angle)
  );

  assign m_tdata = {(OUT_DATA_W-CNT_W-ANG_W)'(0), line_angle, match_count};

  assign res_zero = (match_count == '0) && (line_angle == '0);

  `YLCA_ASSERT_NEXT(a_block_after_eof, clk, rst, s_tvalid && s_tready && s_tlast, !s_tready)
  `YLCA_ASSERT_NOW(a_load_slot_free, clk, rst, cmd.load_out, !m_tvalid || m_tready)
  `YLCA_ASSERT_NOW(a_not_found_zero, clk, rst, m_tvalid && !m_tuser, res_zero)
  `YLCA_ASSERT_NOW(a_found_counted, clk, rst, m_tvalid && m_tuser, match_count != '0)

endmodule
